// ===== rtl/ctd_pkg.sv =====
// Shared types, constants and a helper function for the chunked transfer decoder.
package ctd_pkg;

    localparam int SIZE_BITS = 31;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;

    localparam logic [1:0] TAIL_SKIP = 2'd2;

    typedef enum logic [5:0] {
        PH_DIGITS = 6'b000001,
        PH_EXT    = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_SKIP   = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } ctd_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } ctd_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       body_done;
        logic       decode_error;
    } ctd_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } ctd_hex_t;

    function automatic ctd_hex_t hex_decode(input logic [7:0] c);
        ctd_hex_t h;
        h.ok    = 1'b0;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok    = 1'b1;
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.ok    = 1'b1;
            h.value = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// ===== rtl/ctd_core.sv =====
// Decoder state registers and the per-word next-state logic.
module ctd_core
    import ctd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  ctd_item_t   item,
    output ctd_result_t result
);

    ctd_phase_t           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 pending_cr_reg, pending_cr_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]           skip_left_reg, skip_left_next;

    ctd_hex_t   hex;
    logic       line_end;
    logic       done;
    logic       clean;
    logic [7:0] c;

    assign c   = item.in_byte;
    assign hex = hex_decode(c);

    always_comb begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        digit_seen_next = digit_seen_reg;
        pending_cr_next = pending_cr_reg;
        bytes_left_next = bytes_left_reg;
        skip_left_next  = skip_left_reg;
        result.out_byte  = 8'd0;
        result.out_valid = 1'b0;
        line_end = 1'b0;
        done     = 1'b0;
        clean    = 1'b0;

        case (phase_reg)
            PH_DIGITS: begin
                if (pending_cr_reg) begin
                    if (c == CHAR_LF) begin
                        line_end = 1'b1;
                    end else begin
                        phase_next = PH_ERROR;
                    end
                end else if (c == CHAR_CR) begin
                    pending_cr_next = 1'b1;
                end else if (c == CHAR_SEMI) begin
                    phase_next = PH_EXT;
                end else if (!hex.ok) begin
                    phase_next = PH_ERROR;
                end else if (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                    phase_next = PH_ERROR;
                end else begin
                    size_accum_next = {size_accum_reg[SIZE_BITS-5:0], hex.value};
                    digit_seen_next = 1'b1;
                end
            end
            PH_EXT: begin
                if (pending_cr_reg && c == CHAR_LF) begin
                    line_end = 1'b1;
                end else begin
                    pending_cr_next = (c == CHAR_CR);
                end
            end
            PH_DATA: begin
                result.out_byte  = c;
                result.out_valid = 1'b1;
                bytes_left_next  = bytes_left_reg - SIZE_BITS'(1);
                if (bytes_left_next == '0) begin
                    skip_left_next = TAIL_SKIP;
                    phase_next     = PH_SKIP;
                end
            end
            PH_SKIP: begin
                skip_left_next = skip_left_reg - 2'd1;
                if (skip_left_next == 2'd0) begin
                    size_accum_next = '0;
                    digit_seen_next = 1'b0;
                    pending_cr_next = 1'b0;
                    phase_next      = PH_DIGITS;
                end
            end
            PH_DONE: begin
            end
            default: begin
                phase_next = PH_ERROR;
            end
        endcase

        if (line_end) begin
            pending_cr_next = 1'b0;
            if (!digit_seen_reg) begin
                phase_next = PH_ERROR;
            end else if (size_accum_reg == '0) begin
                phase_next = PH_DONE;
                done       = 1'b1;
            end else begin
                bytes_left_next = size_accum_reg;
                phase_next      = PH_DATA;
            end
        end

        if (item.end_of_stream && phase_next != PH_DONE && phase_next != PH_ERROR) begin
            clean = (phase_next == PH_SKIP) ||
                    (phase_next == PH_DIGITS && !digit_seen_next && !pending_cr_next);
            if (clean) begin
                phase_next = PH_DONE;
                done       = 1'b1;
            end else begin
                phase_next = PH_ERROR;
            end
        end

        result.body_done    = done && (phase_next != PH_ERROR);
        result.decode_error = (phase_next == PH_ERROR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_DIGITS;
            size_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            pending_cr_reg <= 1'b0;
            bytes_left_reg <= '0;
            skip_left_reg  <= 2'd0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            digit_seen_reg <= digit_seen_next;
            pending_cr_reg <= pending_cr_next;
            bytes_left_reg <= bytes_left_next;
            skip_left_reg  <= skip_left_next;
        end
    end

    // An error is final until reset.
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("decoder left the error phase");

    // A finished body stays finished until reset.
    a_done_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("decoder left the done phase");

    // The payload phase always has at least one byte left to pass.
    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes left");

    // The skip phase only ever has one or two bytes left to skip.
    a_skip_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> (skip_left_reg == 2'd1 || skip_left_reg == 2'd2))
        else $error("skip count out of range");

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
// Top level of the chunked transfer decoder: input register, decoder core, result register.
//
//   Channel  | Direction | Handshake          | Payload
//   s_       | in        | s_valid / s_ready  | s_in_byte, s_end_of_stream
//   m_       | out       | m_valid / m_ready  | m_out_byte, m_out_valid, m_body_done,
//            |           |                    | m_decode_error
//
// Each word yields one result word; one word per cycle is sustained when m_ready stays high.
// An accepted word first sits in the input register; m_valid rises when it moves into the
// result register, and the decoder state is updated as it moves there.
// Reset is synchronous and active low and leaves both registers empty.
// When m_ready is low with a result waiting, the result register holds, the input register fills, and s_ready drops.
module chunked_transfer_decoder
    import ctd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_body_done,
    output logic       m_decode_error
);

    logic        in_valid_reg;
    ctd_item_t   in_item_reg;
    logic        out_valid_reg;
    ctd_result_t out_result_reg;
    ctd_result_t step_result;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ctd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg.in_byte       <= s_in_byte;
            in_item_reg.end_of_stream <= s_end_of_stream;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_byte     = out_result_reg.out_byte;
    assign m_out_valid    = out_result_reg.out_valid;
    assign m_body_done    = out_result_reg.body_done;
    assign m_decode_error = out_result_reg.decode_error;

    // With the result register empty, a waiting word always moves on.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with an empty result register");

    // A stalled result is not overwritten.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_result_reg))
        else $error("stalled result changed");

    // A word that moves into the result register comes from a full input register.
    a_advance_source: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> in_valid_reg)
        else $error("core stepped without an input word");

endmodule

// ===== dv/chunked_transfer_decoder_tb.sv =====
// Self-checking testbench for chunked_transfer_decoder: streams chunked bodies and compares every result word with a built-in decoder model.
`timescale 1ns / 1ps

module chunked_transfer_decoder_tb;
    import ctd_pkg::*;

    localparam int          HOLD_CYCLES  = 200;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          RANDOM_WORDS = 1500;
    localparam logic [35:0] MAX_SIZE     = (36'd1 << SIZE_BITS) - 36'd1;

    typedef enum int {
        END_ZERO_CHUNK,
        END_ON_LAST_PAYLOAD,
        END_IN_TRAILER,
        END_AFTER_TRAILER,
        END_MID_PAYLOAD,
        END_MID_SIZE,
        END_EMPTY_SIZE,
        END_BAD_DIGIT,
        END_OVERFLOW,
        END_LONE_CR,
        END_LARGEST_SIZE
    } stream_end_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_stream;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_out_valid;
    logic       m_body_done;
    logic       m_decode_error;

    ctd_result_t expected_outputs[$];
    ctd_result_t oldest_expected;
    int          error_count  = 0;
    int          words_sent   = 0;
    int          stall_cycles = 0;
    bit          idle_enabled = 1'b1;
    bit          hold_request = 1'b0;

    ctd_phase_t  dec_phase         = PH_DIGITS;
    logic [31:0] dec_size          = '0;
    logic        dec_have_digit    = 1'b0;
    logic        dec_cr_seen       = 1'b0;
    logic [31:0] dec_payload_left  = '0;
    logic [1:0]  dec_trailer_left  = '0;

    chunked_transfer_decoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_out_valid     (m_out_valid),
        .m_body_done     (m_body_done),
        .m_decode_error  (m_decode_error)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    function automatic logic close_size_line();
        dec_cr_seen = 1'b0;
        if (!dec_have_digit) begin
            dec_phase = PH_ERROR;
            return 1'b0;
        end
        if (dec_size == 32'd0) begin
            dec_phase = PH_DONE;
            return 1'b1;
        end
        dec_payload_left = dec_size;
        dec_phase = PH_DATA;
        return 1'b0;
    endfunction

    function automatic ctd_result_t predict_decode(input logic [7:0] b, input logic eos);
        ctd_result_t r;
        logic        finished;
        logic [35:0] grown;
        int          nib;
        r = '0;
        finished = 1'b0;
        nib = hex_nibble(b);
        case (dec_phase)
            PH_DIGITS: begin
                if (dec_cr_seen) begin
                    if (b == CHAR_LF) finished = close_size_line();
                    else dec_phase = PH_ERROR;
                end else if (b == CHAR_CR) begin
                    dec_cr_seen = 1'b1;
                end else if (b == CHAR_SEMI) begin
                    dec_phase = PH_EXT;
                end else if (nib < 0) begin
                    dec_phase = PH_ERROR;
                end else begin
                    grown = {dec_size, 4'h0} + 36'(nib);
                    if (grown > MAX_SIZE) begin
                        dec_phase = PH_ERROR;
                    end else begin
                        dec_size = grown[31:0];
                        dec_have_digit = 1'b1;
                    end
                end
            end
            PH_EXT: begin
                if (dec_cr_seen && b == CHAR_LF) finished = close_size_line();
                else dec_cr_seen = (b == CHAR_CR);
            end
            PH_DATA: begin
                r.out_byte = b;
                r.out_valid = 1'b1;
                dec_payload_left = dec_payload_left - 32'd1;
                if (dec_payload_left == 32'd0) begin
                    dec_trailer_left = TAIL_SKIP;
                    dec_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                dec_trailer_left = dec_trailer_left - 2'd1;
                if (dec_trailer_left == 2'd0) begin
                    dec_size = '0;
                    dec_have_digit = 1'b0;
                    dec_cr_seen = 1'b0;
                    dec_phase = PH_DIGITS;
                end
            end
            PH_DONE: begin
            end
            default: begin
                dec_phase = PH_ERROR;
            end
        endcase
        if (eos && dec_phase != PH_DONE && dec_phase != PH_ERROR) begin
            if (dec_phase == PH_SKIP ||
                (dec_phase == PH_DIGITS && !dec_have_digit && !dec_cr_seen)) begin
                dec_phase = PH_DONE;
                finished = 1'b1;
            end else begin
                dec_phase = PH_ERROR;
            end
        end
        r.decode_error = (dec_phase == PH_ERROR);
        r.body_done = finished && (dec_phase != PH_ERROR);
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic upper;
        upper = 1'($urandom_range(0, 1));
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eos);
        if (idle_enabled && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        s_end_of_stream <= eos;
        do @(posedge aclk); while (!s_ready);
        expected_outputs.push_back(predict_decode(b, eos));
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_size_line(input int unsigned size, input bit with_ext);
        int         ndig;
        int         k;
        logic [7:0] b;
        ndig = 1;
        while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
        repeat ($urandom_range(0, 2)) send_word(hex_char(4'h0), 1'b0);
        for (k = ndig - 1; k >= 0; k--) send_word(hex_char(4'(size >> (4 * k))), 1'b0);
        if (with_ext) begin
            send_word(CHAR_SEMI, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
                send_word(b, 1'b0);
            end
        end
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
    endtask

    task automatic send_chunk(input int unsigned size);
        send_size_line(size, $urandom_range(0, 3) == 0);
        repeat (size) send_word(8'($urandom_range(0, 255)), 1'b0);
        repeat (2) send_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_directed_chunks();
        send_word(hex_char(4'h1), 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        repeat (3) send_word(8'h30, 1'b0);
        send_word(8'h32, 1'b0);
        send_word(CHAR_SEMI, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(8'h21, 1'b0);
        send_word(CHAR_CR, 1'b0);
        send_word(CHAR_LF, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
    endtask

    task automatic test_receiver_hold();
        hold_request = 1'b1;
        send_chunk(48);
    endtask

    task automatic test_random_chunks();
        int first;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) == 0) send_chunk($urandom_range(25, 200));
            else send_chunk($urandom_range(1, 24));
        end
    endtask

    task automatic test_full_rate_chunks();
        repeat (6) send_chunk($urandom_range(1, 20));
    endtask

    task automatic test_stream_end();
        stream_end_t kind;
        int          n;
        logic [7:0]  b;
        kind = stream_end_t'($urandom_range(0, int'(END_LARGEST_SIZE)));
        n = $urandom_range(2, 8);
        case (kind)
            END_ZERO_CHUNK: begin
                send_size_line(0, $urandom_range(0, 1));
            end
            END_ON_LAST_PAYLOAD: begin
                send_size_line(n, 1'b0);
                repeat (n - 1) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            END_IN_TRAILER, END_AFTER_TRAILER: begin
                send_size_line(n, 1'b0);
                repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
                if (kind == END_AFTER_TRAILER) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            END_MID_PAYLOAD: begin
                send_size_line(n, 1'b0);
                repeat ($urandom_range(0, n - 2)) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            END_MID_SIZE: begin
                send_word(hex_char(4'($urandom_range(0, 15))), 1'b1);
            end
            END_EMPTY_SIZE: begin
                if ($urandom_range(0, 1) == 1) begin
                    send_word(CHAR_SEMI, 1'b0);
                    send_word(8'h78, 1'b0);
                end
                send_word(CHAR_CR, 1'b0);
                send_word(CHAR_LF, 1'b0);
            end
            END_BAD_DIGIT: begin
                do b = 8'($urandom_range(0, 255));
                while (hex_nibble(b) >= 0 || b == CHAR_CR || b == CHAR_SEMI);
                send_word(b, 1'b0);
            end
            END_OVERFLOW: begin
                repeat ($urandom_range(0, 2)) send_word(hex_char(4'h0), 1'b0);
                send_word(hex_char(4'($urandom_range(8, 15))), 1'b0);
                repeat (7) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
            end
            END_LONE_CR: begin
                send_word(hex_char(4'($urandom_range(1, 15))), 1'b0);
                send_word(CHAR_CR, 1'b0);
                do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
                send_word(b, 1'b0);
            end
            default: begin
                send_word(hex_char(4'h7), 1'b0);
                repeat (7) send_word(hex_char(4'hF), 1'b0);
                send_word(CHAR_CR, 1'b0);
                send_word(CHAR_LF, 1'b0);
                repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        repeat (8) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                $error("result word with none expected: out_byte %02h", m_out_byte);
                error_count++;
            end else begin
                oldest_expected = expected_outputs.pop_front();
                if (m_out_byte !== oldest_expected.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           oldest_expected.out_byte, m_out_byte);
                    error_count++;
                end
                if (m_out_valid !== oldest_expected.out_valid) begin
                    $error("out_valid: expected %0b, got %0b",
                           oldest_expected.out_valid, m_out_valid);
                    error_count++;
                end
                if (m_body_done !== oldest_expected.body_done) begin
                    $error("body_done: expected %0b, got %0b",
                           oldest_expected.body_done, m_body_done);
                    error_count++;
                end
                if (m_decode_error !== oldest_expected.decode_error) begin
                    $error("decode_error: expected %0b, got %0b",
                           oldest_expected.decode_error, m_decode_error);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_end_of_stream = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_chunks();
        test_receiver_hold();
        test_random_chunks();
        idle_enabled = 1'b0;
        test_full_rate_chunks();
        test_stream_end();
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
